FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/pgcg_pkg.sv
package pgcg_pkg;

  localparam int AxisMax    = 16;
  localparam int StoreDepth = 4096;
  localparam int FracBits   = 16;

  localparam int AxisW  = $clog2(AxisMax);          // coordinate width
  localparam int SizeW  = AxisW + 1;                // size value width
  localparam int AddrW  = $clog2(StoreDepth);
  localparam int IndexW = 12;
  localparam int DataW  = 32;
  localparam int RegW   = 32;

  // Register indexes.
  localparam logic [2:0] RegSizeX = 3'd0;
  localparam logic [2:0] RegSizeY = 3'd1;
  localparam logic [2:0] RegSizeZ = 3'd2;
  localparam logic [2:0] RegInvX  = 3'd3;
  localparam logic [2:0] RegInvY  = 3'd4;
  localparam logic [2:0] RegInvZ  = 3'd5;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

FILE: hdl/periodic_grid_central_gradient_unit.sv
// Central-difference gradient on a periodic 3D grid. Samples live in a
// single-port synchronous memory of 4096 words; a write command (op 0) stores
// one sample in the S_WRITE state and produces no result. A query command
// (op 1) splits the linear index into x, y and z by repeated subtraction of
// the configured row and plane sizes (at most 16 steps each), forms the six
// wrapped neighbor addresses, reads them one per cycle through the single
// memory port, and scales the three differences through one shared
// multiplier. A query inside the grid passes through the index split, the
// address step, the six memory reads and the scaling of the three
// differences before its word is delivered; a query beyond the grid goes
// from the z split straight to the output state. The word appears on
// cell_echo and grad_x/y/z for exactly one cycle with done high; the receiver
// cannot stall it. busy is high from acceptance until the word is delivered.
// Queries beyond the configured grid return zero gradients. Size registers of
// 0 act as 1, and values above 16 act as 16. Reading a cell that was never
// written returns an undefined value.
`include "assert_macros.svh"

module periodic_grid_central_gradient_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [pgcg_pkg::IndexW-1:0]       cell_index,
  input  logic signed [pgcg_pkg::DataW-1:0] sample,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [pgcg_pkg::RegW-1:0]         cfg_data,
  output logic                              done,
  output logic [pgcg_pkg::IndexW-1:0]       cell_echo,
  output logic signed [pgcg_pkg::DataW-1:0] grad_x,
  output logic signed [pgcg_pkg::DataW-1:0] grad_y,
  output logic signed [pgcg_pkg::DataW-1:0] grad_z
);

  localparam int AW = pgcg_pkg::AxisW;
  localparam int SW = pgcg_pkg::SizeW;
  localparam int MW = pgcg_pkg::AddrW;
  localparam int IW = pgcg_pkg::IndexW;
  localparam int DW = pgcg_pkg::DataW;
  localparam int LW = 3 * AW + 1;   // linear address math width

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SPLIT_Z, S_SPLIT_Y, S_ADDR, S_READ, S_LAST,
    S_SCALE, S_WAIT1, S_WAIT2, S_OUT
  } state_t;

  // Configuration.
  logic [SW-1:0]      size_x, size_y, size_z;
  logic [DW-1:0]      inv_x, inv_y, inv_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SW'(pgcg_pkg::AxisMax);
      size_y <= SW'(pgcg_pkg::AxisMax);
      size_z <= SW'(pgcg_pkg::AxisMax);
      inv_x  <= DW'(1) << pgcg_pkg::FracBits;
      inv_y  <= DW'(1) << pgcg_pkg::FracBits;
      inv_z  <= DW'(1) << pgcg_pkg::FracBits;
    end else if (cfg_we) begin
      case (cfg_index)
        pgcg_pkg::RegSizeX: size_x <= cfg_data[SW-1:0];
        pgcg_pkg::RegSizeY: size_y <= cfg_data[SW-1:0];
        pgcg_pkg::RegSizeZ: size_z <= cfg_data[SW-1:0];
        pgcg_pkg::RegInvX:  inv_x  <= cfg_data;
        pgcg_pkg::RegInvY:  inv_y  <= cfg_data;
        pgcg_pkg::RegInvZ:  inv_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped sizes.
  logic [SW-1:0] sx, sy, sz;
  always_comb begin
    sx = (size_x == '0) ? SW'(1) : (size_x > SW'(pgcg_pkg::AxisMax)) ?
         SW'(pgcg_pkg::AxisMax) : size_x;
    sy = (size_y == '0) ? SW'(1) : (size_y > SW'(pgcg_pkg::AxisMax)) ?
         SW'(pgcg_pkg::AxisMax) : size_y;
    sz = (size_z == '0) ? SW'(1) : (size_z > SW'(pgcg_pkg::AxisMax)) ?
         SW'(pgcg_pkg::AxisMax) : size_z;
  end

  // Sample memory.
  logic [DW-1:0] field_store [pgcg_pkg::StoreDepth];
  logic          mem_we;
  logic [MW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      field_store[mem_addr] <= mem_wdata;
    end
    mem_rdata <= field_store[mem_addr];
  end

  // Datapath registers.
  state_t            state;
  logic [IW-1:0]     idx;
  logic [DW-1:0]     wdata;
  logic [LW-1:0]     plane, rem, zbase, ybase;
  logic [AW-1:0]     x, y, z;
  logic [2:0]        rd_cnt;
  logic [MW:0]       nb_addr [6];
  logic signed [DW:0] nb_val [6];
  logic              in_grid;
  logic [1:0]        sc_cnt;
  logic signed [DW:0] sc_diff;
  logic [DW-1:0]     sc_factor;
  logic signed [DW-1:0] sc_result;
  logic              rd_pend;
  logic [2:0]        rd_slot;

  pgcg_scale u_scale (
    .clk    (clk),
    .diff   (sc_diff),
    .factor (sc_factor),
    .result (sc_result)
  );

  // Neighbor coordinate wrap.
  logic [AW-1:0] xp, xm, yp, ym, zp, zm;
  always_comb begin
    xp = (SW'(x) + SW'(1) >= sx) ? '0 : x + AW'(1);
    xm = (x == '0) ? AW'(sx - SW'(1)) : x - AW'(1);
    yp = (SW'(y) + SW'(1) >= sy) ? '0 : y + AW'(1);
    ym = (y == '0) ? AW'(sy - SW'(1)) : y - AW'(1);
    zp = (SW'(z) + SW'(1) >= sz) ? '0 : z + AW'(1);
    zm = (z == '0) ? AW'(sz - SW'(1)) : z - AW'(1);
  end

  logic [MW:0] cur_nb;
  assign cur_nb = nb_addr[rd_cnt];

  always_comb begin
    mem_we    = (state == S_WRITE);
    mem_wdata = wdata;
    mem_addr  = (state == S_WRITE) ? idx[MW-1:0] : cur_nb[MW-1:0];
  end

  always_comb begin
    case (sc_cnt)
      2'd0:    begin sc_diff = nb_val[0] - nb_val[1]; sc_factor = inv_x; end
      2'd1:    begin sc_diff = nb_val[2] - nb_val[3]; sc_factor = inv_y; end
      default: begin sc_diff = nb_val[4] - nb_val[5]; sc_factor = inv_z; end
    endcase
  end

  logic [LW-1:0] row_x;
  assign row_x = LW'(SW'(x));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      // The word is presented in the cycle after the output state.
      done <= (state == S_OUT);
      // Capture read data in the cycle after each issued read.
      rd_pend <= (state == S_READ);
      if (rd_pend) begin
        nb_val[rd_slot] <= nb_addr[rd_slot][MW] ? '0 :
                           (DW+1)'($signed(mem_rdata));
      end
      rd_slot <= rd_cnt;
      case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            idx   <= cell_index;
            wdata <= sample;
            plane <= LW'(sx) * LW'(sy);
            if (op == pgcg_pkg::OpWrite) begin
              state <= S_WRITE;
            end else begin
              state <= S_SPLIT_Z;
            end
            rem   <= LW'(cell_index);
            z     <= '0;
            y     <= '0;
            zbase <= '0;
            ybase <= '0;
          end
        end
        S_WRITE: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_SPLIT_Z: begin
          // Index must lie below plane * sz; compare the remainder against plane.
          if (rem >= plane) begin
            if (SW'(z) + SW'(1) >= sz) begin
              in_grid <= 1'b0;
              state   <= S_OUT;
            end else begin
              rem   <= rem - plane;
              zbase <= zbase + plane;
              z     <= z + AW'(1);
            end
          end else begin
            in_grid <= 1'b1;
            state   <= S_SPLIT_Y;
          end
        end
        S_SPLIT_Y: begin
          if (rem >= LW'(sx)) begin
            rem   <= rem - LW'(sx);
            ybase <= ybase + LW'(sx);
            y     <= y + AW'(1);
          end else begin
            x     <= AW'(rem);
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          nb_addr[0] <= (MW+1)'(zbase + ybase + LW'(SW'(xp)));
          nb_addr[1] <= (MW+1)'(zbase + ybase + LW'(SW'(xm)));
          nb_addr[2] <= (MW+1)'(zbase + LW'(yp) * LW'(sx) + row_x);
          nb_addr[3] <= (MW+1)'(zbase + LW'(ym) * LW'(sx) + row_x);
          nb_addr[4] <= (MW+1)'(LW'(zp) * plane + ybase + row_x);
          nb_addr[5] <= (MW+1)'(LW'(zm) * plane + ybase + row_x);
          rd_cnt <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          if (rd_cnt == 3'd5) begin
            state <= S_LAST;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_LAST: begin
          sc_cnt <= 2'd0;
          state  <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          case (sc_cnt)
            2'd0:    grad_x <= sc_result;
            2'd1:    grad_y <= sc_result;
            default: grad_z <= sc_result;
          endcase
          if (sc_cnt == 2'd2) begin
            state <= S_OUT;
          end else begin
            sc_cnt <= sc_cnt + 2'd1;
            state  <= S_SCALE;
          end
        end
        S_OUT: begin
          if (!in_grid) begin
            grad_x <= '0;
            grad_y <= '0;
            grad_z <= '0;
          end
          cell_echo <= idx;
          busy      <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted command must raise busy")
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy, "done while still busy")
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done lasted more than one cycle")

endmodule

FILE: hdl/pgcg_scale.sv
// Scales one neighbor difference by an unsigned factor, rounds half away
// from zero and saturates. Two registered stages.
module pgcg_scale (
  input  logic                              clk,
  input  logic signed [pgcg_pkg::DataW:0]   diff,
  input  logic [pgcg_pkg::RegW-1:0]         factor,
  output logic signed [pgcg_pkg::DataW-1:0] result
);

  localparam int MagW  = pgcg_pkg::DataW + 1;
  localparam int ProdW = MagW + pgcg_pkg::RegW;

  logic             neg;
  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] rnd;
  logic [ProdW-1:0] shifted;

  assign mag = diff[pgcg_pkg::DataW] ? MagW'(-diff) : MagW'(diff);

  always_ff @(posedge clk) begin
    prod <= ProdW'(mag) * ProdW'(factor);
    neg  <= diff[pgcg_pkg::DataW];
  end

  always_comb begin
    rnd = prod;
    if (pgcg_pkg::FracBits > 0) begin
      rnd = prod + (ProdW'(1) << (pgcg_pkg::FracBits - 1));
    end
    shifted = rnd >> pgcg_pkg::FracBits;
  end

  always_ff @(posedge clk) begin
    if (neg) begin
      if (shifted >= ProdW'(64'h8000_0000)) begin
        result <= 32'sh8000_0000;
      end else begin
        result <= -$signed(shifted[pgcg_pkg::DataW-1:0]);
      end
    end else begin
      if (shifted > ProdW'(64'h7FFF_FFFF)) begin
        result <= 32'sh7FFF_FFFF;
      end else begin
        result <= $signed(shifted[pgcg_pkg::DataW-1:0]);
      end
    end
  end

endmodule
